// ===== sv/expression_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// Expression tokenizer assertion macros
// Shared helpers for the concurrent checks in the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_TOKENIZER_DEFINES_SVH
`define EXPRESSION_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on every rising edge outside reset.
`define ET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on every rising edge outside reset.
`define ET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/exptok_pkg.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer package
// Widths, character codes, keyword patterns and the types shared by the
// classifier, the request queue and the scanner.
// ----------------------------------------------------------------------------
package exptok_pkg;

  // Field and state widths.
  localparam int POS_W    = 16;
  localparam int LEN_W    = 16;
  localparam int MANT_W   = 48;
  localparam int SCALE_W  = 8;
  localparam int KW_BYTES = 5;
  localparam int KW_W     = KW_BYTES * 8;

  // Queue between classifier and scanner.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
  localparam logic [MANT_W-1:0]  MANT_MAX  = '1;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // Keywords, first character in the low byte.
  localparam logic [KW_W-1:0] KW_AND   = 40'h00_0064_6E61;
  localparam logic [KW_W-1:0] KW_OR    = 40'h00_0000_726F;
  localparam logic [KW_W-1:0] KW_NOT   = 40'h00_0074_6F6E;
  localparam logic [KW_W-1:0] KW_TRUE  = 40'h00_6575_7274;
  localparam logic [KW_W-1:0] KW_FALSE = 40'h65_736C_6166;

  typedef enum logic [4:0] {
    TK_EOF     = 5'd0,
    TK_NUMBER  = 5'd1,
    TK_IDENT   = 5'd2,
    TK_PLUS    = 5'd3,
    TK_MINUS   = 5'd4,
    TK_STAR    = 5'd5,
    TK_SLASH   = 5'd6,
    TK_PERCENT = 5'd7,
    TK_LPAREN  = 5'd8,
    TK_RPAREN  = 5'd9,
    TK_ASSIGN  = 5'd10,
    TK_AND     = 5'd11,
    TK_OR      = 5'd12,
    TK_NOT     = 5'd13,
    TK_LT      = 5'd14,
    TK_GT      = 5'd15,
    TK_LE      = 5'd16,
    TK_GE      = 5'd17,
    TK_EQ_EQ   = 5'd18,
    TK_NE      = 5'd19,
    TK_TRUE    = 5'd20,
    TK_FALSE   = 5'd21,
    TK_ERROR   = 5'd22
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_WORD,
    MODE_OP
  } scan_mode_t;

  // Character classes resolved by the front end.
  typedef enum logic [3:0] {
    CC_SPACE,
    CC_DIGIT,
    CC_DOT,
    CC_ALPHA,
    CC_EQ,
    CC_REL,
    CC_SINGLE,
    CC_BAD,
    CC_END
  } char_class_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } src_item_t;

  typedef struct packed {
    token_kind_t        token_kind;
    logic [POS_W-1:0]   token_start;
    logic [LEN_W-1:0]   token_length;
    logic [MANT_W-1:0]  number_mantissa;
    logic [SCALE_W-1:0] number_scale;
    logic               number_saturated;
    logic [7:0]         bad_char;
    logic               last;
  } token_t;

  typedef struct packed {
    logic [7:0]  char_code;
    char_class_t cls;
    token_kind_t op_kind;
  } queue_entry_t;

endpackage

// ===== sv/expression_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer
// Byte-stream lexer for a small expression language.
// ----------------------------------------------------------------------------
// Takes one source byte per request and sustains one request per cycle
// while out_ready is held and the spill slot is empty; a request that
// yields two tokens (a pending token plus an operator, an error or end of
// source) holds the scanner while the second token drains from the spill
// slot. A request is registered in the four-entry request queue, then in
// the scanner's output register, where its first token is presented.
// Numbers arrive as a decimal mantissa and a count of fraction digits,
// identifiers as start position and length. An error token halts the
// block until reset; requests are still accepted and dropped.
`include "expression_tokenizer_defines.svh"

module expression_tokenizer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  exptok_pkg::src_item_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output exptok_pkg::token_t    out_data
);
  import exptok_pkg::*;

  queue_entry_t class_entry;
  queue_entry_t head_entry;
  logic         queue_full;
  logic         queue_empty;
  logic         head_pop;
  logic         eof_shown;
  logic         non_num_shown;
  logic         no_num_fields;
  logic         error_taken;

  assign in_ready = !queue_full;

  // Front end: classify the incoming byte.
  exptok_classify u_classify (
    .item  (in_data),
    .entry (class_entry)
  );

  // Request queue between the two halves.
  exptok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (class_entry),
    .full      (queue_full),
    .pop       (head_pop),
    .pop_data  (head_entry),
    .empty     (queue_empty)
  );

  // Back end: scan state and token delivery.
  exptok_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (!queue_empty),
    .entry       (head_entry),
    .entry_pop   (head_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // Terms used by the checks below.
  assign eof_shown     = out_valid && out_data.token_kind == TK_EOF;
  assign non_num_shown = out_valid && out_data.token_kind != TK_NUMBER;
  assign no_num_fields = out_data.number_scale == '0 && !out_data.number_saturated;
  assign error_taken   = out_valid && out_ready && out_data.token_kind == TK_ERROR;

  // End of source is always the final token of its request.
  `ET_ASSERT_NOW(a_eof_last, eof_shown, out_data.last, "eof token without last")

  // Only numbers carry a scale or a saturation flag.
  `ET_ASSERT_NOW(a_scale_num, non_num_shown, no_num_fields, "scale on non-number")

  // Nothing follows a delivered error token until reset.
  `ET_ASSERT_NEXT(a_halt_quiet, error_taken, !out_valid, "token after error")

endmodule

// ===== sv/exptok_classify.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer character classifier
// Sorts each incoming request into a character class and resolves the
// token kind of single-character operators.
// ----------------------------------------------------------------------------
module exptok_classify (
  input  exptok_pkg::src_item_t    item,
  output exptok_pkg::queue_entry_t entry
);
  import exptok_pkg::*;

  logic [7:0] c;

  assign c = item.char_code;

  // Class decode, end marker first.
  always_comb begin
    entry.char_code = c;
    entry.op_kind   = TK_ERROR;
    entry.cls       = CC_BAD;
    if (item.end_of_source) begin
      entry.cls = CC_END;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      entry.cls = CC_SPACE;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      entry.cls = CC_DIGIT;
    end else if (c == CH_DOT) begin
      entry.cls = CC_DOT;
    end else if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                 c == CH_UNDER) begin
      entry.cls = CC_ALPHA;
    end else if (c == CH_EQ) begin
      entry.cls = CC_EQ;
    end else if (c == CH_BANG || c == CH_LT || c == CH_GT) begin
      entry.cls = CC_REL;
    end else begin
      entry.cls = CC_SINGLE;
      unique case (c)
        CH_PLUS:   entry.op_kind = TK_PLUS;
        CH_MINUS:  entry.op_kind = TK_MINUS;
        CH_STAR:   entry.op_kind = TK_STAR;
        CH_SLASH:  entry.op_kind = TK_SLASH;
        CH_PCT:    entry.op_kind = TK_PERCENT;
        CH_LPAREN: entry.op_kind = TK_LPAREN;
        CH_RPAREN: entry.op_kind = TK_RPAREN;
        default:   entry.cls     = CC_BAD;
      endcase
    end
  end

endmodule

// ===== sv/exptok_fifo.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer request queue
// Small register FIFO that decouples the classifier from the scanner.
// ----------------------------------------------------------------------------
module exptok_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  exptok_pkg::queue_entry_t push_data,
  output logic                     full,
  input  logic                     pop,
  output exptok_pkg::queue_entry_t pop_data,
  output logic                     empty
);
  import exptok_pkg::*;

  localparam logic [QUEUE_AW-1:0] LAST_IDX = QUEUE_AW'(QUEUE_DEPTH - 1);

  queue_entry_t        mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full     = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + QUEUE_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + QUEUE_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QUEUE_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/exptok_scan.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer scanner
// Holds the scan state, builds numbers, words and operators, and delivers
// up to two tokens per request through an output register and a spill slot.
// ----------------------------------------------------------------------------
module exptok_scan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     entry_valid,
  input  exptok_pkg::queue_entry_t entry,
  output logic                     entry_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output exptok_pkg::token_t       out_data
);
  import exptok_pkg::*;

  // Scan state.
  scan_mode_t                   mode_r, mode_nxt;
  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic [POS_W-1:0]             begin_r, begin_nxt;
  logic [LEN_W-1:0]             run_len_r, run_len_nxt;
  logic [KW_BYTES-1:0][7:0]     kw_buf_r, kw_buf_nxt;
  logic [MANT_W-1:0]            mant_r, mant_nxt;
  logic [SCALE_W-1:0]           frac_r, frac_nxt;
  logic [1:0]                   dots_r, dots_nxt;
  logic [7:0]                   pend_op_r, pend_op_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         halted_r, halted_nxt;

  // Output register and spill slot.
  logic                         out_v_r;
  token_t                       out_data_r;
  logic                         spill_v_r;
  token_t                       spill_data_r;

  // Per-request working signals.
  logic                         can_take;
  logic [LEN_W-1:0]             len_inc;
  logic [MANT_W+3:0]            mant_x10;
  logic                         mant_over;
  token_kind_t                  word_kind;
  token_t                       flush_tok;
  logic                         flush_v;
  logic                         flush_halt;
  logic                         use_flush;
  token_t                       new_tok;
  logic                         new_v;
  token_t                       tok_a, tok_b;
  logic                         a_v, b_v;

  assign can_take  = !spill_v_r && (!out_v_r || out_ready);
  assign entry_pop = entry_valid && can_take;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // Saturating length count.
  assign len_inc = (run_len_r == LEN_MAX) ? run_len_r : run_len_r + LEN_W'(1);

  // Mantissa times ten plus the new digit, checked against the clamp value.
  assign mant_x10  = ({4'b0, mant_r} << 3) + ({4'b0, mant_r} << 1) +
                     (MANT_W + 4)'(entry.char_code[3:0]);
  assign mant_over = |mant_x10[MANT_W+3:MANT_W];

  // Keyword match on a finished word.
  always_comb begin
    word_kind = TK_IDENT;
    if (run_len_r == LEN_W'(3) && kw_buf_r == KW_AND) begin
      word_kind = TK_AND;
    end else if (run_len_r == LEN_W'(2) && kw_buf_r == KW_OR) begin
      word_kind = TK_OR;
    end else if (run_len_r == LEN_W'(3) && kw_buf_r == KW_NOT) begin
      word_kind = TK_NOT;
    end else if (run_len_r == LEN_W'(4) && kw_buf_r == KW_TRUE) begin
      word_kind = TK_TRUE;
    end else if (run_len_r == LEN_W'(5) && kw_buf_r == KW_FALSE) begin
      word_kind = TK_FALSE;
    end
  end

  // Token for whatever is pending when a request ends it.
  always_comb begin
    flush_tok              = '0;
    flush_tok.token_start  = begin_r;
    flush_tok.token_length = run_len_r;
    flush_v                = (mode_r != MODE_IDLE);
    flush_halt             = 1'b0;
    unique case (mode_r)
      MODE_NUM: begin
        flush_tok.token_kind       = TK_NUMBER;
        flush_tok.number_mantissa  = mant_r;
        flush_tok.number_scale     = frac_r;
        flush_tok.number_saturated = ovf_r;
      end
      MODE_WORD: begin
        flush_tok.token_kind      = word_kind;
        flush_tok.number_mantissa = (word_kind == TK_TRUE) ? MANT_W'(1) : '0;
      end
      MODE_OP: begin
        flush_tok.token_length = LEN_W'(1);
        if (pend_op_r == CH_BANG) begin
          // A bang with no equals sign after it is an error.
          flush_tok.token_kind = TK_ERROR;
          flush_tok.bad_char   = CH_BANG;
          flush_halt           = 1'b1;
        end else if (pend_op_r == CH_EQ) begin
          flush_tok.token_kind = TK_ASSIGN;
        end else if (pend_op_r == CH_LT) begin
          flush_tok.token_kind = TK_LT;
        end else begin
          flush_tok.token_kind = TK_GT;
        end
      end
      default: begin
        flush_tok.token_kind = TK_EOF;
      end
    endcase
  end

  // Main scan step for the request at the head of the queue.
  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    begin_nxt   = begin_r;
    run_len_nxt = run_len_r;
    kw_buf_nxt  = kw_buf_r;
    mant_nxt    = mant_r;
    frac_nxt    = frac_r;
    dots_nxt    = dots_r;
    pend_op_nxt = pend_op_r;
    ovf_nxt     = ovf_r;
    halted_nxt  = halted_r;
    use_flush   = 1'b0;
    new_tok     = '0;
    new_v       = 1'b0;

    if (entry_pop && !halted_r) begin
      if (entry.cls == CC_END) begin
        // Flush, then end of source unless the flush was an error.
        use_flush = 1'b1;
        if (flush_halt) begin
          halted_nxt = 1'b1;
        end else begin
          new_v               = 1'b1;
          new_tok.token_kind  = TK_EOF;
          new_tok.token_start = pos_r;
          mode_nxt            = MODE_IDLE;
          begin_nxt           = '0;
          run_len_nxt         = '0;
          kw_buf_nxt          = '0;
          mant_nxt            = '0;
          frac_nxt            = '0;
          dots_nxt            = '0;
          pend_op_nxt         = '0;
          ovf_nxt             = 1'b0;
          pos_nxt             = '0;
        end
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (mode_r == MODE_NUM && (entry.cls == CC_DIGIT || entry.cls == CC_DOT)) begin
          // Number continues; past the second dot only the length grows.
          run_len_nxt = len_inc;
          if (dots_r < 2'd2) begin
            if (entry.cls == CC_DOT) begin
              dots_nxt = dots_r + 2'd1;
            end else begin
              if (mant_over) begin
                mant_nxt = MANT_MAX;
                ovf_nxt  = 1'b1;
              end else begin
                mant_nxt = mant_x10[MANT_W-1:0];
              end
              if (dots_r == 2'd1 && frac_r != SCALE_MAX) begin
                frac_nxt = frac_r + SCALE_W'(1);
              end
            end
          end
        end else if (mode_r == MODE_WORD &&
                     (entry.cls == CC_ALPHA || entry.cls == CC_DIGIT)) begin
          // Word continues; only its first bytes are kept.
          if (run_len_r < LEN_W'(KW_BYTES)) begin
            kw_buf_nxt[run_len_r[2:0]] = entry.char_code;
          end
          run_len_nxt = len_inc;
        end else if (mode_r == MODE_OP && entry.cls == CC_EQ) begin
          // Two-character comparison operator.
          new_v                = 1'b1;
          new_tok.token_start  = begin_r;
          new_tok.token_length = LEN_W'(2);
          if (pend_op_r == CH_EQ) begin
            new_tok.token_kind = TK_EQ_EQ;
          end else if (pend_op_r == CH_BANG) begin
            new_tok.token_kind = TK_NE;
          end else if (pend_op_r == CH_LT) begin
            new_tok.token_kind = TK_LE;
          end else begin
            new_tok.token_kind = TK_GE;
          end
          mode_nxt    = MODE_IDLE;
          begin_nxt   = '0;
          run_len_nxt = '0;
          kw_buf_nxt  = '0;
          mant_nxt    = '0;
          frac_nxt    = '0;
          dots_nxt    = '0;
          pend_op_nxt = '0;
          ovf_nxt     = 1'b0;
        end else begin
          // The pending token ends here and this character starts anew.
          use_flush = 1'b1;
          if (flush_halt) begin
            halted_nxt = 1'b1;
          end else begin
            mode_nxt    = MODE_IDLE;
            begin_nxt   = '0;
            run_len_nxt = '0;
            kw_buf_nxt  = '0;
            mant_nxt    = '0;
            frac_nxt    = '0;
            dots_nxt    = '0;
            pend_op_nxt = '0;
            ovf_nxt     = 1'b0;
            unique case (entry.cls)
              CC_SPACE: begin
              end
              CC_DIGIT: begin
                mode_nxt    = MODE_NUM;
                begin_nxt   = pos_r;
                run_len_nxt = LEN_W'(1);
                mant_nxt    = MANT_W'(entry.char_code[3:0]);
              end
              CC_ALPHA: begin
                mode_nxt      = MODE_WORD;
                begin_nxt     = pos_r;
                run_len_nxt   = LEN_W'(1);
                kw_buf_nxt[0] = entry.char_code;
              end
              CC_EQ, CC_REL: begin
                mode_nxt    = MODE_OP;
                begin_nxt   = pos_r;
                pend_op_nxt = entry.char_code;
              end
              CC_SINGLE: begin
                new_v                = 1'b1;
                new_tok.token_kind   = entry.op_kind;
                new_tok.token_start  = pos_r;
                new_tok.token_length = LEN_W'(1);
              end
              default: begin
                // Unexpected character, including a dot outside a number.
                new_v                = 1'b1;
                new_tok.token_kind   = TK_ERROR;
                new_tok.token_start  = pos_r;
                new_tok.token_length = LEN_W'(1);
                new_tok.bad_char     = entry.char_code;
                halted_nxt           = 1'b1;
              end
            endcase
          end
        end
      end
    end
  end

  // Order the one or two tokens of this request and mark the final one.
  always_comb begin
    tok_a = new_tok;
    a_v   = new_v;
    tok_b = new_tok;
    b_v   = 1'b0;
    if (use_flush && flush_v) begin
      tok_a = flush_tok;
      a_v   = 1'b1;
      b_v   = new_v;
    end
    tok_a.last = !b_v;
    tok_b.last = 1'b1;
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      pos_r     <= '0;
      begin_r   <= '0;
      run_len_r <= '0;
      kw_buf_r  <= '0;
      mant_r    <= '0;
      frac_r    <= '0;
      dots_r    <= '0;
      pend_op_r <= '0;
      ovf_r     <= 1'b0;
      halted_r  <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      begin_r   <= begin_nxt;
      run_len_r <= run_len_nxt;
      kw_buf_r  <= kw_buf_nxt;
      mant_r    <= mant_nxt;
      frac_r    <= frac_nxt;
      dots_r    <= dots_nxt;
      pend_op_r <= pend_op_nxt;
      ovf_r     <= ovf_nxt;
      halted_r  <= halted_nxt;
    end
  end

  // Output valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spill_v_r <= 1'b0;
    end else if (spill_v_r && (!out_v_r || out_ready)) begin
      out_v_r   <= 1'b1;
      spill_v_r <= 1'b0;
    end else if (entry_pop) begin
      out_v_r   <= a_v;
      spill_v_r <= b_v;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (spill_v_r && (!out_v_r || out_ready)) begin
      out_data_r <= spill_data_r;
    end else if (entry_pop) begin
      if (a_v) begin
        out_data_r <= tok_a;
      end
      spill_data_r <= tok_b;
    end
  end

endmodule
